>>> rtl/uv_sphere_mesh_generator_unit_assert.svh
// Assertion macros for the UV sphere mesh generator checker.
// Requires clk and arst_n in the scope of use.
`ifndef UV_SPHERE_MESH_GENERATOR_UNIT_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_UNIT_ASSERT_SVH

// check while out of reset
`define UVS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("uvs assertion failed");

// check at every edge, reset included
`define UVS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("uvs assertion failed");

`endif

>>> rtl/uvs_pkg.sv
// Shared types, constants and tables of the UV sphere mesh generator.
// No dependencies.
package uvs_pkg;
	localparam int CntW  = 9;
	localparam int FldW  = 17;
	localparam int CorW  = 20;
	localparam int ZW    = 18;
	localparam int QuoW  = 25;
	localparam int TrigBits = 16;
	localparam logic [CorW-1:0] CordicInit = 20'd39796;

	localparam logic [2:0] PH_TOP  = 3'd0;
	localparam logic [2:0] PH_RING = 3'd1;
	localparam logic [2:0] PH_BOT  = 3'd2;
	localparam logic [2:0] PH_TCAP = 3'd3;
	localparam logic [2:0] PH_QUAD = 3'd4;
	localparam logic [2:0] PH_BCAP = 3'd5;

	localparam logic [1:0] REG_SLICE  = 2'd0;
	localparam logic [1:0] REG_STACK  = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam logic [1:0] REG_CCW    = 2'd3;

	typedef struct packed {
		logic restart;
	} item_t;

	typedef struct packed {
		logic [CntW-1:0] slice_count;
		logic [CntW-1:0] stack_count;
		logic [15:0]     radius;
		logic            ccw_winding;
	} cfg_t;

	function automatic logic [ZW-1:0] atan_step(input logic [3:0] k);
		logic [ZW-1:0] v;
		case (k)
			4'd0: v = 18'h02000;
			4'd1: v = 18'h012E4;
			4'd2: v = 18'h009FB;
			4'd3: v = 18'h00511;
			4'd4: v = 18'h0028B;
			4'd5: v = 18'h00145;
			4'd6: v = 18'h000A2;
			4'd7: v = 18'h00051;
			4'd8: v = 18'h00028;
			4'd9: v = 18'h00014;
			4'd10: v = 18'h0000A;
			4'd11: v = 18'h00005;
			4'd12: v = 18'h00002;
			4'd13: v = 18'h00001;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

>>> rtl/uv_sphere_mesh_generator_unit.sv
// UV sphere mesh generator. Each request yields one result: all vertices first
// (top pole, ring vertices, bottom pole), then all triangles; restart begins again.
// A ring vertex runs through the shared bit-serial divider (2 x 25 steps), the
// shared 16-step CORDIC (run for both angles) and four passes through the one
// multiplier; a pole or triangle result uses none of these. Two requests
// may queue ahead of the generator. Results are held in an output register.
// Top level: APB registers, front queue and back end. Depends on uvs_pkg,
// uvs_front, uvs_back.
module uv_sphere_mesh_generator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_vertex,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [16:0]        corner_a,
	output logic [16:0]        corner_b,
	output logic [16:0]        corner_c,
	output logic               last_item
);
	uvs_pkg::cfg_t  cfg_q;
	uvs_pkg::item_t q_item;
	logic           q_valid, q_pop;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slice_count <= 9'd10;
			cfg_q.stack_count <= 9'd10;
			cfg_q.radius      <= 16'd256;
			cfg_q.ccw_winding <= 1'b1;
		end else if (wr_en) begin
			case (paddr[3:2])
				uvs_pkg::REG_SLICE:  cfg_q.slice_count <= pwdata[8:0];
				uvs_pkg::REG_STACK:  cfg_q.stack_count <= pwdata[8:0];
				uvs_pkg::REG_RADIUS: cfg_q.radius      <= pwdata[15:0];
				uvs_pkg::REG_CCW:    cfg_q.ccw_winding <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			uvs_pkg::REG_SLICE:  prdata = {23'd0, cfg_q.slice_count};
			uvs_pkg::REG_STACK:  prdata = {23'd0, cfg_q.stack_count};
			uvs_pkg::REG_RADIUS: prdata = {16'd0, cfg_q.radius};
			uvs_pkg::REG_CCW:    prdata = {31'd0, cfg_q.ccw_winding};
			default:             prdata = '0;
		endcase
	end

	uvs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	uvs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_vertex (is_vertex),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.tex_u     (tex_u),
		.tex_v     (tex_v),
		.corner_a  (corner_a),
		.corner_b  (corner_b),
		.corner_c  (corner_c),
		.last_item (last_item)
	);
endmodule

>>> rtl/uvs_front.sv
// Front end: accepts requests into a two-entry queue for the back end.
// Depends on uvs_pkg.
module uvs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          restart,
	output logic          q_valid,
	output uvs_pkg::item_t q_item,
	input  logic          q_pop
);
	uvs_pkg::item_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q].restart <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

>>> rtl/uvs_back.sv
// Back end: walks the mesh, runs the divider, CORDIC and multiplier for ring vertices.
// Depends on uvs_pkg.
module uvs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uvs_pkg::cfg_t         cfg,
	input  logic                  q_valid,
	input  uvs_pkg::item_t        q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  is_vertex,
	output logic signed [16:0]    pos_x,
	output logic signed [16:0]    pos_y,
	output logic signed [16:0]    pos_z,
	output logic [16:0]           tex_u,
	output logic [16:0]           tex_v,
	output logic [16:0]           corner_a,
	output logic [16:0]           corner_b,
	output logic [16:0]           corner_c,
	output logic                  last_item
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIVU = 3'd1;
	localparam logic [2:0] S_DIVV = 3'd2;
	localparam logic [2:0] S_CORT = 3'd3;
	localparam logic [2:0] S_CORP = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]  state_q;
	logic [2:0]  phase_q;
	logic [8:0]  ring_q, col_q;
	logic        half_q;

	logic [8:0]  sl, st;
	logic [9:0]  rv;
	logic [16:0] s_idx, bb_idx;

	logic [2:0]  ep;
	logic [8:0]  er, ec;
	logic        eh;
	logic [2:0]  n_phase;
	logic [9:0]  n_ring, n_col;
	logic        n_half;
	logic [16:0] ta, tb, tc, qa, qb, ba;
	logic        t_last;

	logic [8:0]  wi_q, wsl_q, wst_q;
	logic [15:0] wr_q;

	logic [24:0] dnum_q, dquo_q;
	logic [8:0]  drem_q;
	logic [4:0]  dcnt_q;
	logic [8:0]  divisor;
	logic [9:0]  rem_sh;
	logic        rem_ge;
	logic [24:0] quo_nx;
	logic [15:0] th_q, phi_q;

	logic signed [19:0] CordicInitS;
	logic signed [19:0] cx_q, cy_q;
	logic signed [17:0] cz_q;
	logic [1:0]  cq_q;
	logic [3:0]  ck_q;
	logic signed [19:0] sx, sy;
	logic signed [19:0] cx_nx, cy_nx;
	logic signed [17:0] cz_nx;
	logic signed [19:0] cos_o, sin_o;
	logic signed [19:0] sin_t_q, cos_t_q, sin_p_q, cos_p_q;

	logic [1:0]  mcnt_q;
	logic signed [19:0] ma, mb;
	logic signed [39:0] prod;
	logic signed [39:0] prod_r;
	logic signed [23:0] rm;
	logic signed [23:0] rs_q, px_q, py_q, pz_q;

	logic        r_vert_q, r_last_q;
	logic signed [16:0] r_x_q, r_y_q, r_z_q;
	logic [16:0] r_u_q, r_v_q, r_a_q, r_b_q, r_c_q;

	logic        ov_q, o_vert_q, o_last_q;
	logic signed [16:0] o_x_q, o_y_q, o_z_q;
	logic [16:0] o_u_q, o_v_q, o_a_q, o_b_q, o_c_q;
	logic        out_free;

	function automatic logic signed [16:0] sat17(input logic signed [23:0] v);
		if (v > 24'sd65535) begin
			return 17'sd65535;
		end else if (v < -24'sd65535) begin
			return -17'sd65535;
		end
		return v[16:0];
	endfunction

	function automatic logic [16:0] satu(input logic [24:0] v);
		if (v > 25'd65536) begin
			return 17'd65536;
		end
		return v[16:0];
	endfunction

	assign CordicInitS = $signed(uvs_pkg::CordicInit);

	always_comb begin
		sl = cfg.slice_count;
		if (sl < 9'd3) begin
			sl = 9'd3;
		end else if (sl > 9'd256) begin
			sl = 9'd256;
		end
		st = cfg.stack_count;
		if (st < 9'd2) begin
			st = 9'd2;
		end else if (st > 9'd256) begin
			st = 9'd256;
		end
	end

	assign rv     = {1'b0, sl} + 10'd1;
	assign s_idx  = 17'(19'((st - 9'd1) * rv) + 19'd1);
	assign bb_idx = s_idx - {7'd0, rv};

	always_comb begin
		if (q_item.restart || phase_q > uvs_pkg::PH_BCAP) begin
			ep = uvs_pkg::PH_TOP;
		end else begin
			ep = phase_q;
		end
		er = q_item.restart ? 9'd0 : ring_q;
		ec = q_item.restart ? 9'd0 : col_q;
		eh = q_item.restart ? 1'b0 : half_q;
		n_phase = ep;
		n_ring  = {1'b0, er};
		n_col   = {1'b0, ec};
		n_half  = eh;
		t_last  = 1'b0;
		qa = 17'(19'(er * rv) + 19'(ec) + 19'd1);
		qb = qa + {7'd0, rv};
		ba = bb_idx + {8'd0, ec};
		ta = '0;
		tb = '0;
		tc = '0;
		case (ep)
			uvs_pkg::PH_TOP: begin
				n_phase = uvs_pkg::PH_RING;
				n_ring  = 10'd1;
				n_col   = 10'd0;
				n_half  = 1'b0;
			end
			uvs_pkg::PH_RING: begin
				n_col = {1'b0, ec} + 10'd1;
				if (n_col > {1'b0, sl}) begin
					n_col  = 10'd0;
					n_ring = {1'b0, er} + 10'd1;
				end
				if (n_ring >= {1'b0, st}) begin
					n_phase = uvs_pkg::PH_BOT;
					n_ring  = 10'd0;
					n_col   = 10'd0;
				end
			end
			uvs_pkg::PH_BOT: begin
				n_phase = uvs_pkg::PH_TCAP;
				n_ring  = 10'd0;
				n_col   = 10'd0;
			end
			uvs_pkg::PH_TCAP: begin
				ta = '0;
				tb = cfg.ccw_winding ? {8'd0, ec} + 17'd1 : {8'd0, ec} + 17'd2;
				tc = cfg.ccw_winding ? {8'd0, ec} + 17'd2 : {8'd0, ec} + 17'd1;
				n_col = {1'b0, ec} + 10'd1;
				if (n_col >= {1'b0, sl}) begin
					n_col   = 10'd0;
					n_ring  = 10'd0;
					n_half  = 1'b0;
					n_phase = (st > 9'd2) ? uvs_pkg::PH_QUAD : uvs_pkg::PH_BCAP;
				end
			end
			uvs_pkg::PH_QUAD: begin
				if (!eh) begin
					ta = qa;
					tb = cfg.ccw_winding ? qb : qa + 17'd1;
					tc = cfg.ccw_winding ? qa + 17'd1 : qb;
					n_half = 1'b1;
				end else begin
					ta = qb;
					tb = cfg.ccw_winding ? qb + 17'd1 : qa + 17'd1;
					tc = cfg.ccw_winding ? qa + 17'd1 : qb + 17'd1;
					n_half = 1'b0;
					n_col  = {1'b0, ec} + 10'd1;
					if (n_col >= {1'b0, sl}) begin
						n_col  = 10'd0;
						n_ring = {1'b0, er} + 10'd1;
					end
				end
				if (n_ring >= {1'b0, st} - 10'd2) begin
					n_phase = uvs_pkg::PH_BCAP;
					n_ring  = 10'd0;
					n_col   = 10'd0;
					n_half  = 1'b0;
				end
			end
			default: begin
				t_last = ({1'b0, ec} + 10'd1) >= {1'b0, sl};
				ta = s_idx;
				tb = cfg.ccw_winding ? ba + 17'd1 : ba;
				tc = cfg.ccw_winding ? ba : ba + 17'd1;
				n_col = {1'b0, ec} + 10'd1;
				if (t_last) begin
					n_phase = uvs_pkg::PH_TOP;
					n_ring  = 10'd0;
					n_col   = 10'd0;
					n_half  = 1'b0;
				end
			end
		endcase
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	assign divisor = (state_q == S_DIVU) ? wsl_q : wst_q;
	assign rem_sh  = {drem_q, dnum_q[24]};
	assign rem_ge  = rem_sh >= {1'b0, divisor};
	assign quo_nx  = {dquo_q[23:0], rem_ge};

	assign sx = cx_q >>> ck_q;
	assign sy = cy_q >>> ck_q;
	always_comb begin
		if (!cz_q[17]) begin
			cx_nx = cx_q - sy;
			cy_nx = cy_q + sx;
			cz_nx = cz_q - $signed(uvs_pkg::atan_step(ck_q));
		end else begin
			cx_nx = cx_q + sy;
			cy_nx = cy_q - sx;
			cz_nx = cz_q + $signed(uvs_pkg::atan_step(ck_q));
		end
	end

	always_comb begin
		case (cq_q)
			2'd0: begin cos_o = cx_nx;  sin_o = cy_nx;  end
			2'd1: begin cos_o = -cy_nx; sin_o = cx_nx;  end
			2'd2: begin cos_o = -cx_nx; sin_o = -cy_nx; end
			default: begin cos_o = cy_nx; sin_o = -cx_nx; end
		endcase
	end

	always_comb begin
		case (mcnt_q)
			2'd0: begin ma = {4'd0, wr_q}; mb = sin_p_q; end
			2'd1: begin ma = {4'd0, wr_q}; mb = cos_p_q; end
			2'd2: begin ma = rs_q[19:0];   mb = cos_t_q; end
			default: begin ma = rs_q[19:0]; mb = sin_t_q; end
		endcase
	end
	assign prod   = ma * mb;
	assign prod_r = prod + 40'sd32768;
	assign rm     = prod_r[39:16];

	assign out_free = !ov_q || !out_stall;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					wi_q  <= er;
					wsl_q <= sl;
					wst_q <= st;
					wr_q  <= cfg.radius;
					dnum_q <= {ec, 16'd0};
					drem_q <= '0;
					dquo_q <= '0;
					dcnt_q <= '0;
					r_vert_q <= (ep <= uvs_pkg::PH_BOT);
					r_last_q <= t_last;
					r_x_q <= '0;
					r_z_q <= '0;
					r_u_q <= '0;
					r_v_q <= (ep == uvs_pkg::PH_BOT) ? 17'd65536 : 17'd0;
					r_y_q <= (ep == uvs_pkg::PH_TOP) ? $signed({1'b0, cfg.radius}) :
					         (ep == uvs_pkg::PH_BOT) ? -$signed({1'b0, cfg.radius}) : 17'sd0;
					r_a_q <= ta;
					r_b_q <= tb;
					r_c_q <= tc;
				end
			end
			S_DIVU, S_DIVV: begin
				drem_q <= rem_ge ? 9'(rem_sh - {1'b0, divisor}) : rem_sh[8:0];
				dquo_q <= quo_nx;
				dnum_q <= {dnum_q[23:0], 1'b0};
				dcnt_q <= dcnt_q + 5'd1;
				if (dcnt_q == 5'd24) begin
					dcnt_q <= '0;
					drem_q <= '0;
					dquo_q <= '0;
					if (state_q == S_DIVU) begin
						th_q   <= quo_nx[15:0];
						r_u_q  <= satu(quo_nx);
						dnum_q <= {wi_q, 16'd0};
					end else begin
						phi_q <= quo_nx[16:1];
						r_v_q <= satu(quo_nx);
						cx_q  <= CordicInitS;
						cy_q  <= '0;
						cz_q  <= {4'd0, th_q[13:0]};
						cq_q  <= th_q[15:14];
						ck_q  <= '0;
					end
				end
			end
			S_CORT, S_CORP: begin
				cx_q <= cx_nx;
				cy_q <= cy_nx;
				cz_q <= cz_nx;
				ck_q <= ck_q + 4'd1;
				if (ck_q == 4'd15) begin
					cx_q <= CordicInitS;
					cy_q <= '0;
					cz_q <= {4'd0, phi_q[13:0]};
					cq_q <= phi_q[15:14];
					ck_q <= '0;
				end
			end
			S_MUL: begin
				case (mcnt_q)
					2'd0: rs_q <= rm;
					2'd1: py_q <= rm;
					2'd2: px_q <= rm;
					default: pz_q <= rm;
				endcase
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd3) begin
					r_x_q <= sat17(px_q);
					r_y_q <= sat17(py_q);
					r_z_q <= sat17(rm);
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_CORT && ck_q == 4'd15) begin
			sin_t_q <= sin_o;
			cos_t_q <= cos_o;
		end
		if (state_q == S_CORP && ck_q == 4'd15) begin
			sin_p_q <= sin_o;
			cos_p_q <= cos_o;
			mcnt_q  <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= uvs_pkg::PH_TOP;
			ring_q  <= '0;
			col_q   <= '0;
			half_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						phase_q <= n_phase;
						ring_q  <= n_ring[8:0];
						col_q   <= n_col[8:0];
						half_q  <= n_half;
						state_q <= (ep == uvs_pkg::PH_RING) ? S_DIVU : S_DONE;
					end
				end
				S_DIVU: if (dcnt_q == 5'd24) state_q <= S_DIVV;
				S_DIVV: if (dcnt_q == 5'd24) state_q <= S_CORT;
				S_CORT: if (ck_q == 4'd15) state_q <= S_CORP;
				S_CORP: if (ck_q == 4'd15) state_q <= S_MUL;
				S_MUL:  if (mcnt_q == 2'd3) state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			o_vert_q <= r_vert_q;
			o_x_q    <= r_vert_q ? r_x_q : 17'sd0;
			o_y_q    <= r_vert_q ? r_y_q : 17'sd0;
			o_z_q    <= r_vert_q ? r_z_q : 17'sd0;
			o_u_q    <= r_vert_q ? r_u_q : 17'd0;
			o_v_q    <= r_vert_q ? r_v_q : 17'd0;
			o_a_q    <= r_vert_q ? 17'd0 : r_a_q;
			o_b_q    <= r_vert_q ? 17'd0 : r_b_q;
			o_c_q    <= r_vert_q ? 17'd0 : r_c_q;
			o_last_q <= r_vert_q ? 1'b0 : r_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;
	assign is_vertex = o_vert_q;
	assign pos_x     = o_x_q;
	assign pos_y     = o_y_q;
	assign pos_z     = o_z_q;
	assign tex_u     = o_u_q;
	assign tex_v     = o_v_q;
	assign corner_a  = o_a_q;
	assign corner_b  = o_b_q;
	assign corner_c  = o_c_q;
	assign last_item = o_last_q;
endmodule

>>> rtl/uvs_checker.sv
// Port-level checker for the UV sphere mesh generator, bound to the top level.
// Depends on uv_sphere_mesh_generator_unit_assert.svh.
`include "uv_sphere_mesh_generator_unit_assert.svh"

module uvs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               is_vertex,
	input logic signed [16:0] pos_x,
	input logic [16:0]        tex_v,
	input logic [16:0]        corner_a,
	input logic               last_item
);
	`UVS_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid)
	`UVS_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(corner_a))
	`UVS_ASSERT(a_tri_clean, out_valid && !is_vertex |-> pos_x == 17'sd0 && tex_v == 17'd0)
	`UVS_ASSERT(a_vert_clean, out_valid && is_vertex |-> corner_a == 17'd0 && !last_item)
endmodule

bind uv_sphere_mesh_generator_unit uvs_checker u_chk (.*);
